FILE: hdl/afsc_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive frame skip controller package
// Shared constants, register indexes and the skip pattern table.
// ----------------------------------------------------------------------------
package afsc_pkg;

   localparam int unsigned LEVELS      = 12;
   localparam int unsigned LEVEL_W     = 4;
   localparam int unsigned CREDIT_W    = 6;

   // Target speed in tenths of a percent; the slow drop counts in steps of 50
   localparam logic [9:0]  TARGET_TENTHS = 10'd900;
   // floor(x / 50) for x <= 900 as (x * 5243) >> 18
   localparam logic [12:0] DIV50_RECIP   = 13'd5243;
   localparam int unsigned DIV50_SHIFT   = 18;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(LEVELS - 1);

   localparam logic [15:0] FAST_RESET   = 16'd995;
   localparam logic [15:0] SLOW_RESET   = 16'd800;
   localparam logic [3:0]  NEAR_RESET   = 4'd8;
   localparam logic [31:0] WARMUP_RESET = 32'd24;

   typedef enum logic [1:0] {
      CSR_FAST_THRESHOLD = 2'd0,
      CSR_SLOW_THRESHOLD = 2'd1,
      CSR_NEAR_LIMIT     = 2'd2,
      CSR_WARMUP_FRAMES  = 2'd3
   } csr_index_type;

   typedef logic [LEVELS-1:0] pattern_row_type;

   // Bit p of row l is set when phase p is dropped at skip level l
   localparam pattern_row_type SKIP_PATTERN [LEVELS] = '{
      12'b000000000000,
      12'b100000000000,
      12'b100000100000,
      12'b100010001000,
      12'b100100100100,
      12'b101001010010,
      12'b101010101010,
      12'b101101011010,
      12'b110110110110,
      12'b111011101110,
      12'b111110111110,
      12'b111111111110
   };

endpackage

FILE: hdl/adaptive_frame_skip_controller_unit.sv
// ----------------------------------------------------------------------------
// Adaptive frame skip controller
// Per-frame skip decision, automatic level adjustment and key handling.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per video frame (speed, frame count, pause level,
//            bitmap flags and key presses), valid/ready handshake.
//   rsp_*  : one result item per request item, valid/ready handshake.
//   csr_*  : register writes (index, data); always ready. Write only while
//            the block holds no item.
// Flow: an accepted item is held in the input register, is evaluated and
//   lands in the result register once that register is free, and its
//   result is then offered on rsp_*.
// Throughput: one item per cycle unless the receiver stalls. All the work,
//   including the credit rule and the skip pattern lookup, is a single pass of
//   logic between the two registers; controller state updates as items cross.
// Reset: synchronous; both stages empty, level 0, auto mode and throttling
//   on, phase 0, credit cleared, registers at their defaults.
// Receiver stall: the result register holds; the input register still takes
//   one more item, then req_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module adaptive_frame_skip_controller_unit (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [15:0]                  req_speed_tenths,
   input  logic [31:0]                  req_frame_number,
   input  logic                         req_paused,
   input  logic                         req_bitmap_changed,
   input  logic                         req_debug_bitmap_changed,
   input  logic                         req_increment_key,
   input  logic                         req_decrement_key,
   input  logic                         req_throttle_key,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_skip_frame,
   output logic                         rsp_frame_drawn,
   output logic [3:0]                   rsp_frame_phase,
   output logic [3:0]                   rsp_skip_level,
   output logic                         rsp_auto_mode,
   output logic                         rsp_throttle_on,
   output logic signed [4:0]            rsp_reported_level,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  afsc_pkg::csr_index_type      csr_index,
   input  logic [31:0]                  csr_data
);
   import afsc_pkg::*;

   // Configuration registers
   logic [15:0] fast_thr_ff;
   logic [15:0] slow_thr_ff;
   logic [3:0]  near_limit_ff;
   logic [31:0] warmup_ff;

   // Controller state
   logic [LEVEL_W-1:0]         level_ff,    level_in;
   logic                       auto_ff,     auto_in;
   logic                       throttle_ff, throttle_in;
   logic [LEVEL_W-1:0]         phase_ff,    phase_in;
   logic signed [CREDIT_W-1:0] credit_ff,   credit_in;
   logic                       was_paused_ff, was_paused_in;
   logic                       dbg_seen_ff,   dbg_seen_in;

   // Input register
   logic        in_valid_ff;
   logic [15:0] speed_ff;
   logic [31:0] frame_ff;
   logic        paused_ff;
   logic        bitmap_ff;
   logic        dbg_bitmap_ff;
   logic        inc_key_ff;
   logic        dec_key_ff;
   logic        thr_key_ff;

   // Result register
   logic              out_valid_ff;
   logic              skip_ff,     skip_in;
   logic              drawn_ff,    drawn_in;
   logic [3:0]        used_phase_ff;
   logic signed [4:0] reported_ff, reported_in;
   logic [3:0]        out_level_ff;
   logic              out_auto_ff;
   logic              out_throttle_ff;

   logic advance;
   logic move;

   // Output stage frees when empty or taken; input stage frees when it moves on
   assign advance   = !out_valid_ff || rsp_ready;
   assign move      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // Per-frame evaluation
   // ---------------------------------------------------------------------
   always_comb begin
      logic                 was_eff;
      logic                 rule_due;
      logic                 eligible;
      logic [9:0]           below_target;
      logic [22:0]          drop_prod;
      logic [4:0]           drop;
      logic signed [6:0]    credit_work;
      logic signed [6:0]    credit_neg;
      logic [4:0]           level_sum;
      logic [LEVEL_W-1:0]   lvl;
      logic                 au;

      // Pause is taken first and counts towards this frame's rule
      was_eff  = was_paused_ff || paused_ff;
      skip_in  = SKIP_PATTERN[level_ff][phase_ff];
      drawn_in = !skip_in && bitmap_ff;
      rule_due = drawn_in && throttle_ff && auto_ff && (phase_ff == '0);
      eligible = !was_eff && !dbg_seen_ff && (frame_ff > warmup_ff);

      below_target = (speed_ff < {6'd0, TARGET_TENTHS})
                   ? (TARGET_TENTHS - speed_ff[9:0]) : 10'd0;
      drop_prod    = {13'd0, below_target} * {10'd0, DIV50_RECIP};
      drop         = drop_prod[DIV50_SHIFT +: 5];

      credit_work = 7'(credit_ff);
      credit_neg  = '0;
      level_sum   = '0;
      lvl         = level_ff;

      if (rule_due && eligible) begin
         if (speed_ff >= fast_thr_ff) begin
            credit_work = credit_work + 7'sd1;
            if (credit_work >= 7'sd3) begin
               credit_work = '0;
               if (lvl != '0) begin
                  lvl = lvl - 1'b1;
               end
            end
         end else begin
            if (speed_ff < slow_thr_ff) begin
               credit_work = credit_work - $signed({2'b00, drop});
            end else if (lvl < near_limit_ff) begin
               credit_work = credit_work - 7'sd1;
            end
            // Settle pairs of slow credit into level steps
            if (credit_work <= -7'sd2) begin
               credit_neg  = -credit_work;
               credit_work = credit_neg[0] ? -7'sd1 : 7'sd0;
               level_sum   = {1'b0, lvl} + {1'b0, credit_neg[4:1]};
               lvl = (level_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : level_sum[LEVEL_W-1:0];
            end
         end
      end

      credit_in     = credit_work[CREDIT_W-1:0];
      was_paused_in = rule_due ? paused_ff : was_eff;
      dbg_seen_in   = (dbg_seen_ff && !rule_due) || dbg_bitmap_ff;
      phase_in      = (phase_ff == LEVEL_MAX) ? '0 : phase_ff + 1'b1;

      // Keys: increment, then decrement, then throttle
      au = auto_ff;
      if (inc_key_ff) begin
         if (au) begin
            au  = 1'b0;
            lvl = '0;
         end else if (lvl >= LEVEL_MAX) begin
            lvl = '0;
            au  = 1'b1;
         end else begin
            lvl = lvl + 1'b1;
         end
      end
      if (dec_key_ff) begin
         if (au) begin
            au  = 1'b0;
            lvl = LEVEL_MAX;
         end else if (lvl == '0) begin
            au  = 1'b1;
         end else begin
            lvl = lvl - 1'b1;
         end
      end

      level_in    = lvl;
      auto_in     = au;
      throttle_in = throttle_ff ^ thr_key_ff;
      // -(level + 1) is the bitwise inverse of level
      reported_in = au ? ~$signed({1'b0, lvl}) : $signed({1'b0, lvl});
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_thr_ff   <= FAST_RESET;
         slow_thr_ff   <= SLOW_RESET;
         near_limit_ff <= NEAR_RESET;
         warmup_ff     <= WARMUP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FAST_THRESHOLD: fast_thr_ff   <= csr_data[15:0];
            CSR_SLOW_THRESHOLD: slow_thr_ff   <= csr_data[15:0];
            CSR_NEAR_LIMIT:     near_limit_ff <= csr_data[3:0];
            CSR_WARMUP_FRAMES:  warmup_ff     <= csr_data;
            default:            ;
         endcase
      end
   end

   // Advance the controller state as an item crosses to the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= '0;
         auto_ff       <= 1'b1;
         throttle_ff   <= 1'b1;
         phase_ff      <= '0;
         credit_ff     <= '0;
         was_paused_ff <= 1'b0;
         dbg_seen_ff   <= 1'b0;
      end else if (move) begin
         level_ff      <= level_in;
         auto_ff       <= auto_in;
         throttle_ff   <= throttle_in;
         phase_ff      <= phase_in;
         credit_ff     <= credit_in;
         was_paused_ff <= was_paused_in;
         dbg_seen_ff   <= dbg_seen_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         speed_ff      <= req_speed_tenths;
         frame_ff      <= req_frame_number;
         paused_ff     <= req_paused;
         bitmap_ff     <= req_bitmap_changed;
         dbg_bitmap_ff <= req_debug_bitmap_changed;
         inc_key_ff    <= req_increment_key;
         dec_key_ff    <= req_decrement_key;
         thr_key_ff    <= req_throttle_key;
      end
   end

   // Result register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         skip_ff         <= skip_in;
         drawn_ff        <= drawn_in;
         used_phase_ff   <= phase_ff;
         out_level_ff    <= level_in;
         out_auto_ff     <= auto_in;
         out_throttle_ff <= throttle_in;
         reported_ff     <= reported_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_skip_frame     = skip_ff;
   assign rsp_frame_drawn    = drawn_ff;
   assign rsp_frame_phase    = used_phase_ff;
   assign rsp_skip_level     = out_level_ff;
   assign rsp_auto_mode      = out_auto_ff;
   assign rsp_throttle_on    = out_throttle_ff;
   assign rsp_reported_level = reported_ff;

endmodule

FILE: test/tb_adaptive_frame_skip_controller_unit.sv
// ----------------------------------------------------------------------------
// Adaptive frame skip controller testbench
// Sends frame items under random idling and register sweeps, predicts every
// verdict with an independent model of the controller and compares it field
// by field with the result item that comes back.
// ----------------------------------------------------------------------------
module tb_adaptive_frame_skip_controller_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import afsc_pkg::*;

   localparam int TOP_LEVEL    = LEVELS - 1;
   localparam int TARGET_SPEED = 900;
   localparam int DROP_STEP    = 50;
   localparam int FAST_RUN     = 3;
   // Cycles without any handshake before the run is declared hung
   localparam int STALL_LIMIT  = 2000;
   // Extra wait after the last result, as a generous margin
   localparam int DRAIN_CYCLES = 8;

   // Drop pattern, one row per skip level; phase 0 is the leftmost entry
   localparam bit [0:LEVELS-1] DROP_TABLE [LEVELS] = '{
      12'b000000000000,
      12'b000000000001,
      12'b000001000001,
      12'b000100010001,
      12'b001001001001,
      12'b010010100101,
      12'b010101010101,
      12'b010110101101,
      12'b011011011011,
      12'b011101110111,
      12'b011111011111,
      12'b011111111111
   };

   typedef struct {
      logic [15:0] speed;
      logic [31:0] frame;
      logic        paused;
      logic        bitmap;
      logic        debug;
      logic        inc_key;
      logic        dec_key;
      logic        thr_key;
   } frame_item_type;

   typedef struct {
      logic              skip;
      logic              drawn;
      logic [3:0]        phase;
      logic [3:0]        level;
      logic              auto_mode;
      logic              throttle;
      logic signed [4:0] reported;
   } frame_verdict_type;

   // ------------------------------------------------------------------------
   // Clock, reset and block ports
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid                = 1'b0;
   logic        req_ready;
   logic [15:0] req_speed_tenths         = '0;
   logic [31:0] req_frame_number         = '0;
   logic        req_paused               = 1'b0;
   logic        req_bitmap_changed       = 1'b0;
   logic        req_debug_bitmap_changed = 1'b0;
   logic        req_increment_key        = 1'b0;
   logic        req_decrement_key        = 1'b0;
   logic        req_throttle_key         = 1'b0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_skip_frame;
   logic              rsp_frame_drawn;
   logic [3:0]        rsp_frame_phase;
   logic [3:0]        rsp_skip_level;
   logic              rsp_auto_mode;
   logic              rsp_throttle_on;
   logic signed [4:0] rsp_reported_level;

   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_FAST_THRESHOLD;
   logic [31:0]   csr_data  = '0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   adaptive_frame_skip_controller_unit dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_speed_tenths         (req_speed_tenths),
      .req_frame_number         (req_frame_number),
      .req_paused               (req_paused),
      .req_bitmap_changed       (req_bitmap_changed),
      .req_debug_bitmap_changed (req_debug_bitmap_changed),
      .req_increment_key        (req_increment_key),
      .req_decrement_key        (req_decrement_key),
      .req_throttle_key         (req_throttle_key),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_skip_frame           (rsp_skip_frame),
      .rsp_frame_drawn          (rsp_frame_drawn),
      .rsp_frame_phase          (rsp_frame_phase),
      .rsp_skip_level           (rsp_skip_level),
      .rsp_auto_mode            (rsp_auto_mode),
      .rsp_throttle_on          (rsp_throttle_on),
      .rsp_reported_level       (rsp_reported_level),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   // ------------------------------------------------------------------------
   // Controller model: registers and state, starting at their reset values
   // ------------------------------------------------------------------------
   logic [15:0] fast_limit   = FAST_RESET;
   logic [15:0] slow_limit   = SLOW_RESET;
   logic [3:0]  near_cap     = NEAR_RESET;
   logic [31:0] warmup_count = WARMUP_RESET;

   int level_now     = 0;
   int phase_now     = 0;
   int credit        = 0;
   bit auto_on       = 1'b1;
   bit throttle_on   = 1'b1;
   bit pause_latched = 1'b0;
   bit pause_now     = 1'b0;
   bit debug_latched = 1'b0;

   frame_verdict_type awaited_verdicts[$];

   int req_idle_pct   = 0;
   int rsp_stall_pct  = 0;
   int error_count    = 0;
   int frames_sent    = 0;
   int verdicts_seen  = 0;
   int rule_runs      = 0;
   int level_raises   = 0;
   int level_lowers   = 0;
   int settings_used  = 0;
   int quiet_cycles   = 0;
   logic [31:0] frame_count = '0;

   // Speed credit rule, run on a drawn auto-mode frame at phase 0 with throttling on
   task automatic apply_speed_credit(input logic [15:0] speed, input logic [31:0] frame);
      int spd;
      int drop;
      int k;
      spd = speed;
      if (!pause_latched && !debug_latched && frame > warmup_count) begin
         rule_runs++;
         if (speed >= fast_limit) begin
            // Credit reaching FAST_RUN: clear it and ease off one level, if above 0
            credit++;
            if (credit >= FAST_RUN) begin
               credit = 0;
               if (level_now > 0) begin
                  level_now--;
                  level_lowers++;
               end
            end
         end else begin
            if (speed < slow_limit) begin
               // Above the target the drop is zero, never negative
               drop = (spd < TARGET_SPEED) ? (TARGET_SPEED - spd) / DROP_STEP : 0;
               credit -= drop;
            end else if (level_now < int'(near_cap)) begin
               credit--;
            end
            // Settle in steps of two, each raising the level; the credit
            // still gains even once the level sits at the top
            if (credit <= -2) begin
               k = (-credit) / 2;
               credit += 2 * k;
               level_now = (level_now + k > TOP_LEVEL) ? TOP_LEVEL : level_now + k;
               level_raises++;
            end
         end
      end
      pause_latched = pause_now;
      debug_latched = 1'b0;
   endtask

   // Advance the model by one frame and work out its verdict
   task automatic advance_controller(input frame_item_type it, output frame_verdict_type v);
      int row;
      is_pause_update: begin
         pause_now = it.paused;
         if (it.paused) pause_latched = 1'b1;
      end
      row = (level_now > TOP_LEVEL) ? TOP_LEVEL : level_now;
      v.phase = 4'(phase_now);
      v.skip  = DROP_TABLE[row][phase_now];
      v.drawn = !v.skip && it.bitmap;

      if (v.drawn && throttle_on && auto_on && phase_now == 0)
         apply_speed_credit(it.speed, it.frame);
      if (it.debug) debug_latched = 1'b1;
      phase_now = (phase_now + 1) % LEVELS;

      // Keys in fixed order: increment, decrement, throttle
      if (it.inc_key) begin
         if (auto_on) begin
            auto_on   = 1'b0;
            level_now = 0;
         end else if (level_now >= TOP_LEVEL) begin
            level_now = 0;
            auto_on   = 1'b1;
         end else begin
            level_now++;
         end
      end
      if (it.dec_key) begin
         if (auto_on) begin
            auto_on   = 1'b0;
            level_now = TOP_LEVEL;
         end else if (level_now == 0) begin
            auto_on = 1'b1;
         end else begin
            level_now--;
         end
      end
      if (it.thr_key) throttle_on = !throttle_on;

      v.level     = 4'(level_now);
      v.auto_mode = auto_on;
      v.throttle  = throttle_on;
      v.reported  = auto_on ? 5'(-(level_now + 1)) : 5'(level_now);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: stall at random, then compare each result item in order
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
         error_count++;
      end
   endtask

   frame_verdict_type due;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_verdicts.size() == 0) begin
            $error("result item arrived with no frame outstanding");
            error_count++;
         end else begin
            due = awaited_verdicts.pop_front();
            verdicts_seen++;
            check_field("skip_frame", 32'(due.skip), 32'(rsp_skip_frame));
            check_field("frame_drawn", 32'(due.drawn), 32'(rsp_frame_drawn));
            check_field("frame_phase", 32'(due.phase), 32'(rsp_frame_phase));
            check_field("skip_level", 32'(due.level), 32'(rsp_skip_level));
            check_field("auto_mode", 32'(due.auto_mode), 32'(rsp_auto_mode));
            check_field("throttle_on", 32'(due.throttle), 32'(rsp_throttle_on));
            check_field("reported_level", 32'(due.reported), 32'(rsp_reported_level));
         end
      end
   end

   // Watchdog: any accepted item on any channel resets the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   function automatic frame_item_type make_frame(input logic [15:0] speed,
                                                 input logic [31:0] frame,
                                                 input logic p, b, d, i, dc, t);
      frame_item_type it;
      it.speed   = speed;
      it.frame   = frame;
      it.paused  = p;
      it.bitmap  = b;
      it.debug   = d;
      it.inc_key = i;
      it.dec_key = dc;
      it.thr_key = t;
      return it;
   endfunction

   // Hold valid and payload until accepted, then advance the model
   task automatic send_frame(input frame_item_type it);
      frame_verdict_type v;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid                <= 1'b1;
      req_speed_tenths         <= it.speed;
      req_frame_number         <= it.frame;
      req_paused               <= it.paused;
      req_bitmap_changed       <= it.bitmap;
      req_debug_bitmap_changed <= it.debug;
      req_increment_key        <= it.inc_key;
      req_decrement_key        <= it.dec_key;
      req_throttle_key         <= it.thr_key;
      do @(posedge clock); while (!req_ready);
      advance_controller(it, v);
      awaited_verdicts.push_back(v);
      frames_sent++;
   endtask

   // Mostly plausible frame streams so the credit rule gets exercised;
   // keys are biased to bring the controller back to auto mode and throttling
   function automatic frame_item_type random_frame();
      frame_item_type it;
      frame_count = frame_count + 1;
      if ($urandom_range(99) < 10) begin
         // Noise: every field drawn at random
         it = make_frame(16'($urandom), $urandom, 1'($urandom), 1'($urandom),
                         1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
         return it;
      end
      case ($urandom_range(7))
         0: it.speed = 16'($urandom_range(899));
         1: it.speed = 16'($urandom_range(1100, 800));
         2: it.speed = 16'($urandom_range(2200, 900));
         3: it.speed = 16'($urandom_range(65535));
         4: it.speed = fast_limit;
         5: it.speed = (fast_limit == 0) ? 16'd0 : fast_limit - 16'd1;
         6: it.speed = slow_limit;
         default: it.speed = (slow_limit == 0) ? 16'd0 : slow_limit - 16'd1;
      endcase
      it.frame  = ($urandom_range(99) < 5) ? $urandom : frame_count;
      it.paused = ($urandom_range(99) < 3);
      it.bitmap = ($urandom_range(99) < 90);
      it.debug  = ($urandom_range(99) < 4);
      if (auto_on) begin
         it.inc_key = ($urandom_range(99) < 2);
         it.dec_key = ($urandom_range(99) < 2);
      end else begin
         it.inc_key = ($urandom_range(99) < 20);
         it.dec_key = ($urandom_range(99) < 20);
      end
      it.thr_key = throttle_on ? ($urandom_range(99) < 2) : ($urandom_range(99) < 30);
      return it;
   endfunction

   // Drop valid and wait for every outstanding verdict, then a little longer
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_verdicts.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; valid stays high for the next write
   task automatic post_register(input csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FAST_THRESHOLD: fast_limit   = data[15:0];
         CSR_SLOW_THRESHOLD: slow_limit   = data[15:0];
         CSR_NEAR_LIMIT:     near_cap     = data[3:0];
         CSR_WARMUP_FRAMES:  warmup_count = data;
         default: ;
      endcase
   endtask

   // Reprogram all registers, only once the block has drained
   task automatic write_registers(input logic [15:0] fast, slow,
                                  input logic [3:0] near, input logic [31:0] warm);
      settle();
      post_register(CSR_FAST_THRESHOLD, 32'(fast));
      post_register(CSR_SLOW_THRESHOLD, 32'(slow));
      post_register(CSR_NEAR_LIMIT, 32'(near));
      post_register(CSR_WARMUP_FRAMES, warm);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random_frames(input int count);
      repeat (count) send_frame(random_frame());
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Key wrapping in and out of auto mode, throttle toggling, pause and
   // debugger blocking of the rule, and field extremes, at reset settings
   task automatic test_keys_and_extremes();
      send_frame(make_frame(16'd0, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0));
      send_frame(make_frame(16'd1000, 32'd1, 0, 1, 0, 1, 0, 0));
      send_frame(make_frame(16'd1000, 32'd2, 0, 1, 0, 1, 0, 0));
      send_frame(make_frame(16'd1000, 32'd3, 0, 1, 0, 0, 1, 0));
      send_frame(make_frame(16'd1000, 32'd4, 0, 1, 0, 0, 1, 0));
      send_frame(make_frame(16'd1000, 32'd5, 0, 1, 0, 0, 1, 0));
      send_frame(make_frame(16'd1000, 32'd6, 0, 0, 0, 1, 0, 0));
      send_frame(make_frame(16'd1000, 32'd7, 0, 1, 0, 1, 1, 0));
      send_frame(make_frame(16'd1000, 32'd8, 0, 1, 0, 0, 0, 1));
      send_frame(make_frame(16'd1000, 32'd9, 0, 1, 0, 0, 0, 1));
      send_frame(make_frame(16'd65535, 32'd10, 1, 1, 0, 0, 0, 0));
      send_frame(make_frame(16'd65535, 32'd11, 0, 1, 1, 0, 0, 0));
      // Phase 0 with a pause still latched: rule must not fire
      send_frame(make_frame(16'd65535, 32'd100, 0, 1, 0, 0, 0, 0));
      send_frame(make_frame(16'd900, 32'd24, 0, 1, 0, 0, 0, 0));
      send_frame(make_frame(16'd899, 32'd25, 0, 1, 0, 0, 0, 0));
      send_frame(make_frame(16'd995, 32'd26, 0, 1, 0, 0, 0, 0));
      send_frame(make_frame(16'd994, 32'd27, 0, 0, 1, 0, 0, 0));
      send_frame(make_frame(16'd800, 32'd28, 1, 0, 0, 0, 0, 0));
      send_frame(make_frame(16'd799, 32'd29, 0, 1, 0, 0, 0, 0));
      send_frame(make_frame(16'hAAAA, 32'hAAAA_AAAA, 0, 1, 0, 0, 0, 0));
      send_frame(make_frame(16'h5555, 32'h5555_5555, 0, 1, 0, 0, 0, 0));
      send_frame(make_frame(16'd0, 32'd0, 0, 0, 0, 0, 0, 0));
      send_frame(make_frame(16'hFFFF, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1));
      send_frame(make_frame(16'd0, 32'd0, 0, 1, 0, 0, 0, 1));
   endtask

   // Plausible frame streams at reset settings
   task automatic test_default_settings();
      run_random_frames(350);
   endtask

   // Sweep register corners: all fast, all slow with top-level saturation,
   // slow threshold above the target, near limit beyond the top level,
   // warmup that can never pass, a wide gentle band, then back to reset
   task automatic test_threshold_corners();
      write_registers(16'd0, 16'd0, 4'd0, 32'd0);
      run_random_frames(100);
      write_registers(16'hFFFF, 16'hFFFF, 4'd15, 32'd0);
      run_random_frames(100);
      write_registers(16'd3000, 16'd2000, 4'd12, 32'd10);
      run_random_frames(100);
      write_registers(16'd995, 16'd800, 4'd11, 32'hFFFF_FFFF);
      run_random_frames(100);
      write_registers(16'd1200, 16'd500, 4'd4, 32'd300);
      run_random_frames(100);
      write_registers(FAST_RESET, SLOW_RESET, NEAR_RESET, WARMUP_RESET);
      run_random_frames(100);
   endtask

   // Back-to-back frames at a random near-default setting, no idling
   task automatic test_free_running();
      write_registers(16'($urandom_range(1100, 900)), 16'($urandom_range(900, 600)),
                      4'($urandom_range(15)), 32'($urandom_range(100)));
      run_random_frames(475);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct  = 18;
      rsp_stall_pct = 62;
      test_keys_and_extremes();
      test_default_settings();

      req_idle_pct  = 62;
      rsp_stall_pct = 18;
      test_threshold_corners();

      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      test_free_running();

      settle();
      $display("Ran %0d frames (%0d results checked) over %0d register settings.",
               frames_sent, verdicts_seen, settings_used + 1);
      $display("Credit rule applied %0d times: %0d level raises, %0d level drops.",
               rule_runs, level_raises, level_lowers);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
